### rtl/core/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// shared types and constants of the iso-tp transmit segmenter
// ----------------------------------------------------------------------------
package isotp_pkg;

    localparam int unsigned ID_W  = 29;
    localparam int unsigned LEN_W = 12;

    localparam logic [ID_W-1:0]  TX_CAN_ID_RESET   = 29'd2015;
    localparam logic [LEN_W-1:0] MAX_MESSAGE_BYTES = 12'd4095;
    localparam logic [LEN_W-1:0] SF_MAX_BYTES      = 12'd7;
    localparam logic [3:0]       PCI_FIRST         = 4'h1;
    localparam logic [3:0]       PCI_CONSEC        = 4'h2;
    localparam logic [3:0]       FULL_DLC          = 4'd8;

    // register index of the configuration port
    localparam logic REG_TX_CAN_ID = 1'b0;

    // one emitted can frame, byte 0 is the pci byte
    typedef struct packed {
        logic            eom;
        logic [7:0][7:0] bytes;
        logic [3:0]      dlc;
        logic [ID_W-1:0] id;
    } frame_t;

endpackage

### rtl/core/isotp_cfg.sv
// ----------------------------------------------------------------------------
// isotp_cfg
// apb register holding the transmit identifier
// ----------------------------------------------------------------------------
module isotp_cfg
    import isotp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output logic [ID_W-1:0] tx_can_id
);

    logic [ID_W-1:0] tx_can_id_reg;
    logic [ID_W-1:0] tx_can_id_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TX_CAN_ID);

    always_comb
    begin
        tx_can_id_next = tx_can_id_reg;
        if (wr_en)
        begin
            tx_can_id_next = pwdata[ID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_can_id_reg <= TX_CAN_ID_RESET;
        end
        else
        begin
            tx_can_id_reg <= tx_can_id_next;
        end
    end

    assign prdata    = (paddr[2] == REG_TX_CAN_ID) ? {3'b000, tx_can_id_reg} : 32'd0;
    assign tx_can_id = tx_can_id_reg;

endmodule

### rtl/core/isotp_core.sv
// ----------------------------------------------------------------------------
// isotp_core
// frame assembly: places each byte and decides when a frame is complete
// ----------------------------------------------------------------------------
module isotp_core
    import isotp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] message_length,
    input  logic [ID_W-1:0]  tx_can_id,
    output logic             frame_valid,
    output frame_t           frame
);

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [7:0][7:0]  buf_reg, buf_next;
    logic [2:0]       fill_reg, fill_next;
    logic [3:0]       seq_reg, seq_next;

    logic             start;
    logic             drop;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] rem_base;
    logic [7:0][7:0]  buf_base;
    logic [7:0][7:0]  buf_fill;
    logic [2:0]       fill_base;
    logic [3:0]       seq_base;
    logic [3:0]       fill_inc;
    logic [LEN_W-1:0] rem_dec;
    logic             last;
    logic             emit;

    assign start   = (rem_reg == '0);
    assign drop    = start && (message_length == '0);
    assign len_sat = (message_length > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES
                                                          : message_length;

    // state seen by this byte, a new message opens its first frame here
    always_comb
    begin
        buf_base  = buf_reg;
        fill_base = fill_reg;
        seq_base  = seq_reg;
        rem_base  = rem_reg;
        if (start)
        begin
            buf_base = '0;
            rem_base = len_sat;
            if (len_sat <= SF_MAX_BYTES)
            begin
                buf_base[0] = len_sat[7:0];
                fill_base   = 3'd1;
            end
            else
            begin
                buf_base[0] = {PCI_FIRST, len_sat[11:8]};
                buf_base[1] = len_sat[7:0];
                fill_base   = 3'd2;
                seq_base    = 4'd1;
            end
        end
    end

    always_comb
    begin
        buf_fill            = buf_base;
        buf_fill[fill_base] = data_byte;
    end

    assign fill_inc = {1'b0, fill_base} + 4'd1;
    assign rem_dec  = rem_base - 12'd1;
    assign last     = (rem_dec == '0);
    assign emit     = last || (fill_inc == FULL_DLC);

    assign frame_valid = take && !drop && emit;
    assign frame.eom   = last;
    assign frame.bytes = buf_fill;
    assign frame.dlc   = fill_inc;
    assign frame.id    = tx_can_id;

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        seq_next  = seq_reg;
        rem_next  = rem_reg;
        if (take && !drop)
        begin
            rem_next = rem_dec;
            seq_next = seq_base;
            if (!emit)
            begin
                buf_next  = buf_fill;
                fill_next = fill_inc[2:0];
            end
            else if (last)
            begin
                buf_next  = '0;
                fill_next = 3'd0;
            end
            else
            begin
                // open the next consecutive frame
                buf_next    = '0;
                buf_next[0] = {PCI_CONSEC, seq_base};
                seq_next    = seq_base + 4'd1;
                fill_next   = 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            buf_reg  <= '0;
            fill_reg <= '0;
            seq_reg  <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
            seq_reg  <= seq_next;
        end
    end

endmodule

### rtl/core/isotp_skid.sv
// ----------------------------------------------------------------------------
// isotp_skid
// output register with one skid entry for frames
// ----------------------------------------------------------------------------
module isotp_skid
    import isotp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  frame_t in_frame,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    output frame_t out_frame
);

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    frame_t out_frame_reg, out_frame_next;
    frame_t skid_frame_reg, skid_frame_next;

    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_frame_next  = out_frame_reg;
        skid_frame_next = skid_frame_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || in_valid;
            out_frame_next  = skid_valid_reg ? skid_frame_reg : in_frame;
            skid_valid_next = 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_frame_next = in_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg  <= out_frame_next;
        skid_frame_reg <= skid_frame_next;
    end

    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;

endmodule

### rtl/core/isotp_transmit_segmenter.sv
// ----------------------------------------------------------------------------
// isotp_transmit_segmenter
// iso-tp transmit segmentation of a payload byte stream into can frames
// ----------------------------------------------------------------------------
// Payload bytes enter one per request on the slave side, the message length
// being sampled with the first byte of each message. A message of up to seven
// bytes leaves as one single frame; a longer one as a first frame followed by
// consecutive frames with a sequence number wrapping modulo 16. One byte is
// taken in every cycle while s_tready is high. A completed frame is registered
// into an output register backed by one skid entry, which holds it while the
// sink stalls; s_tready only drops when both hold a frame the sink has not taken.
// Lengths above 4095 cannot occur and a zero length drops the byte. The
// identifier register sits at byte address 0 of the apb port and should only
// be written while no message is in flight.
module isotp_transmit_segmenter
    import isotp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // payload requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], message_length[19:8], zero pad
    // frame requests
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // frame_id[28:0], frame_dlc[32:29],
                                    // frame_byte0..7 in [40:33]..[96:89], zero pad
    output logic         m_tlast,   // end_of_message
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [ID_W-1:0] tx_can_id;
    logic            take;
    logic            core_valid;
    frame_t          core_frame;
    frame_t          out_frame;

    // the identifier register
    isotp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tx_can_id (tx_can_id)
    );

    assign take = s_tvalid && s_tready;

    // byte placement and frame completion
    isotp_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .data_byte      (s_tdata[7:0]),
        .message_length (s_tdata[19:8]),
        .tx_can_id      (tx_can_id),
        .frame_valid    (core_valid),
        .frame          (core_frame)
    );

    // result register and skid entry
    isotp_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_frame  (core_frame),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_frame (out_frame)
    );

    assign m_tdata = {7'b0, out_frame.bytes, out_frame.dlc, out_frame.id};
    assign m_tlast = out_frame.eom;

`ifndef ASSERT_OFF
    // the input only stalls while a frame waits at the output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // every frame carries one to eight bytes
    a_dlc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_frame.dlc != 4'd0) && (out_frame.dlc <= FULL_DLC))
        else $error("frame dlc out of range");

    // only the last frame of a message is shortened
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> out_frame.dlc == FULL_DLC)
        else $error("short frame not marked last");

    // a shortened frame has its top byte zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_frame.dlc != FULL_DLC) |-> out_frame.bytes[7] == 8'd0)
        else $error("unused frame byte not zero");
`endif

endmodule
